>>> rtl/core/thks_pkg.sv
// Shared types and constants for the top-k health selector.
// No dependencies; imported by every module of the core.
package thks_pkg;

  localparam int MAX_UNITS_DEF     = 64;
  localparam int MAX_ADDITIONS_DEF = 20;
  localparam int ID_W              = 8;
  localparam int HEALTH_W          = 16;
  localparam int SEL_W             = 7;
  localparam logic [SEL_W-1:0] SEL_RESET = 7'd4;

  typedef struct packed {
    logic                valid;
    logic                mark;
    logic [ID_W-1:0]     id;
    logic [HEALTH_W-1:0] health;
  } unit_t;

  typedef enum logic [1:0] {
    MODE_DUMP,
    MODE_FIRST,
    MODE_ADD
  } mode_t;

  typedef struct packed {
    logic  en;
    logic  restart;
    mode_t mode;
  } scan_ctl_t;

endpackage

>>> rtl/core/thks_cell.sv
// One storage cell of the unit chain: holds one unit and passes it on.
// Depends on thks_pkg.
module thks_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           shift_en,
  input  logic           clear,
  input  thks_pkg::unit_t d,
  output thks_pkg::unit_t q
);
  import thks_pkg::*;

  logic                valid_r;
  logic                mark_r;
  logic [ID_W-1:0]     id_r;
  logic [HEALTH_W-1:0] health_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else if (clear) begin
      valid_r <= 1'b0;
      mark_r  <= 1'b0;
    end else if (shift_en) begin
      valid_r <= d.valid;
      mark_r  <= d.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      id_r     <= d.id;
      health_r <= d.health;
    end
  end

  assign q = '{valid: valid_r, mark: mark_r, id: id_r, health: health_r};

endmodule

>>> rtl/core/thks_scan.sv
// Running maximum tracker fed by the head of the unit chain.
// Depends on thks_pkg.
module thks_scan #(
  parameter int MAX_UNITS = thks_pkg::MAX_UNITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  thks_pkg::scan_ctl_t          ctl,
  input  thks_pkg::unit_t              head,
  input  logic                         head_mark,
  input  logic [$clog2(MAX_UNITS)-1:0] pos,
  output logic [thks_pkg::ID_W-1:0]    best_id,
  output logic [$clog2(MAX_UNITS)-1:0] best_pos
);
  import thks_pkg::*;

  localparam int P_W = $clog2(MAX_UNITS);

  logic                found_r;
  logic [HEALTH_W-1:0] health_r;
  logic [ID_W-1:0]     id_r;
  logic [P_W-1:0]      pos_r;
  logic                found_eff;
  logic                cand;

  assign found_eff = found_r && !ctl.restart;

  always_comb begin
    case (ctl.mode)
      MODE_FIRST: cand = head.valid && (!found_eff || head.health > health_r);
      MODE_ADD:   cand = head.valid && !head_mark &&
                         (!found_eff || head.health >= health_r);
      default:    cand = 1'b0;
    endcase
  end

  assign best_id  = cand ? head.id : id_r;
  assign best_pos = cand ? pos : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.en) begin
      found_r <= found_eff || cand;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && cand) begin
      health_r <= head.health;
      id_r     <= head.id;
      pos_r    <= pos;
    end
  end

endmodule

>>> rtl/core/top_k_health_selector_core.sv
// Top level of the top-k health selector: unit chain, scan unit and control.
// Depends on thks_pkg, thks_cell and thks_scan.
//
// Usage: present one unit per transaction on in_unit_id / in_unit_health with
// start high; it is taken at a clock edge where busy is low. in_last_unit
// closes the set; busy then rises and stays high until the last result.
// While busy is low a unit is loaded whenever start is high; units beyond MAX_UNITS are dropped.
// After the last unit the chain rotates one cell per cycle past the scan
// unit, so one pass covers all MAX_UNITS cells. If the set fits within
// select_count, ids stream out in load order during a single pass. Otherwise
// each chosen id takes one pass: at most min(max(select_count, 1),
// MAX_ADDITIONS + 1) passes, each result registered at the end of its pass.
// Each result is shown for one cycle with out_valid; the receiver cannot
// stall, so results are never held back. out_last_chosen marks the final
// result of a set. select_count is written through cfg_valid / cfg_ready
// only while busy is low, no unit is held in the chain and start is low.
// Reset empties the chain and sets select_count to 4; the chain is also
// emptied at the end of every set.
module top_k_health_selector_core #(
  parameter int MAX_UNITS     = thks_pkg::MAX_UNITS_DEF,
  parameter int MAX_ADDITIONS = thks_pkg::MAX_ADDITIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [thks_pkg::ID_W-1:0]     in_unit_id,
  input  logic [thks_pkg::HEALTH_W-1:0] in_unit_health,
  input  logic                          in_last_unit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [thks_pkg::SEL_W-1:0]    cfg_select_count,
  output logic                          out_valid,
  output logic [thks_pkg::ID_W-1:0]     out_chosen_id,
  output logic                          out_last_chosen
);
  import thks_pkg::*;

  localparam int P_W   = $clog2(MAX_UNITS);
  localparam int CNT_W = $clog2(MAX_UNITS + 1);
  localparam int ADD_W = $clog2(MAX_ADDITIONS + 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t             state_r;
  mode_t              mode_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [SEL_W-1:0]   sel_r;
  logic [P_W-1:0]     pos_r;
  logic [SEL_W-1:0]   picked_r;
  logic [SEL_W-1:0]   picked_nxt;
  logic [ADD_W-1:0]   adds_r;
  logic [ADD_W-1:0]   adds_nxt;
  logic               pend_valid_r;
  logic [P_W-1:0]     pend_pos_r;
  logic               out_valid_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_last_r;

  unit_t              chain_q [MAX_UNITS];
  unit_t              head;
  unit_t              head_in;
  logic               head_mark;
  logic               scanning;
  logic               accept;
  logic               load_shift;
  logic               shift_en;
  logic               pass_end;
  logic               last_pick;
  logic               finish;
  scan_ctl_t          scan_ctl;
  logic [ID_W-1:0]    best_id;
  logic [P_W-1:0]     best_pos;

  assign scanning   = (state_r == ST_SCAN);
  assign busy       = scanning;
  assign cfg_ready  = !scanning && !start && (count_r == '0);
  assign accept     = start && !scanning;
  assign load_shift = accept && (count_r < CNT_W'(MAX_UNITS));
  assign shift_en   = load_shift || scanning;
  assign pass_end   = scanning && (pos_r == P_W'(MAX_UNITS - 1));
  assign count_nxt  = load_shift ? count_r + CNT_W'(1) : count_r;
  assign picked_nxt = picked_r + SEL_W'(1);
  assign adds_nxt   = adds_r + ADD_W'(1);

  assign head      = chain_q[MAX_UNITS-1];
  assign head_mark = head.mark || (pend_valid_r && (pos_r == pend_pos_r));

  always_comb begin
    if (scanning) begin
      head_in      = head;
      head_in.mark = head_mark;
    end else begin
      head_in = '{valid: 1'b1, mark: 1'b0, id: in_unit_id, health: in_unit_health};
    end
  end

  always_comb begin
    case (mode_r)
      MODE_FIRST: last_pick = (sel_r <= SEL_W'(1));
      MODE_ADD:   last_pick = (picked_nxt >= sel_r) ||
                              (adds_nxt >= ADD_W'(MAX_ADDITIONS));
      default:    last_pick = 1'b1;
    endcase
  end

  assign finish = pass_end && last_pick;

  genvar gi;
  generate
    for (gi = 0; gi < MAX_UNITS; gi++) begin : g_chain
      if (gi == 0) begin : g_head
        thks_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .clear    (finish),
          .d        (head_in),
          .q        (chain_q[gi])
        );
      end else begin : g_body
        thks_cell u_cell (
          .clk      (clk),
          .rst_n    (rst_n),
          .shift_en (shift_en),
          .clear    (finish),
          .d        (chain_q[gi-1]),
          .q        (chain_q[gi])
        );
      end
    end
  endgenerate

  assign scan_ctl = '{en: scanning, restart: (pos_r == '0), mode: mode_r};

  thks_scan #(
    .MAX_UNITS (MAX_UNITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (scan_ctl),
    .head      (head),
    .head_mark (head_mark),
    .pos       (pos_r),
    .best_id   (best_id),
    .best_pos  (best_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mode_r       <= MODE_DUMP;
      count_r      <= '0;
      sel_r        <= SEL_RESET;
      pos_r        <= '0;
      picked_r     <= '0;
      adds_r       <= '0;
      pend_valid_r <= 1'b0;
      pend_pos_r   <= '0;
      out_valid_r  <= 1'b0;
      out_id_r     <= '0;
      out_last_r   <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        sel_r <= cfg_select_count;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            count_r <= count_nxt;
            if (in_last_unit) begin
              state_r      <= ST_SCAN;
              pos_r        <= '0;
              picked_r     <= '0;
              adds_r       <= '0;
              pend_valid_r <= 1'b0;
              mode_r       <= (SEL_W'(count_nxt) <= sel_r) ? MODE_DUMP : MODE_FIRST;
            end
          end
        end
        ST_SCAN: begin
          pos_r <= pass_end ? '0 : pos_r + P_W'(1);
          case (mode_r)
            MODE_DUMP: begin
              if (head.valid) begin
                out_valid_r <= 1'b1;
                out_id_r    <= head.id;
                out_last_r  <= pass_end;
              end
            end
            MODE_FIRST, MODE_ADD: begin
              if (pass_end) begin
                out_valid_r  <= 1'b1;
                out_id_r     <= best_id;
                out_last_r   <= last_pick;
                pend_valid_r <= 1'b1;
                pend_pos_r   <= best_pos;
                picked_r     <= picked_nxt;
                if (mode_r == MODE_ADD) begin
                  adds_r <= adds_nxt;
                end
                mode_r <= MODE_ADD;
              end
            end
            default: begin
              mode_r <= MODE_DUMP;
            end
          endcase
          if (finish) begin
            state_r <= ST_IDLE;
            count_r <= '0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_chosen_id   = out_id_r;
  assign out_last_chosen = out_last_r;

  a_strobe_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a selection in progress");

  a_last_ends_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_chosen |-> !busy)
    else $error("busy still high after final result");

  a_last_unit_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_last_unit |=> busy)
    else $error("closing unit did not start selection");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_UNITS))
    else $error("loaded count beyond chain length");

  a_pick_bound: assert property (@(posedge clk) disable iff (!rst_n)
    scanning |-> adds_r <= ADD_W'(MAX_ADDITIONS))
    else $error("more additions than allowed");

endmodule

>>> tb/tb_top_k_health_selector_core.sv
// Testbench for top_k_health_selector_core: drives unit sets and select_count writes,
// predicts the chosen ids in order and checks every result transaction.
// Depends on thks_pkg and the core RTL only.
module tb_top_k_health_selector_core;
  import thks_pkg::*;

  localparam int UNITS       = MAX_UNITS_DEF;
  localparam int ADDS        = MAX_ADDITIONS_DEF;
  localparam int PASS_CYCLES = UNITS + 8;
  localparam int CYCLE_LIMIT = 500_000;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } chosen_t;

  logic                clk;
  logic                rst_n            = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  logic [ID_W-1:0]     in_unit_id       = '0;
  logic [HEALTH_W-1:0] in_unit_health   = '0;
  logic                in_last_unit     = 1'b0;
  logic                cfg_valid        = 1'b0;
  logic                cfg_ready;
  logic [SEL_W-1:0]    cfg_select_count = '0;
  logic                out_valid;
  logic [ID_W-1:0]     out_chosen_id;
  logic                out_last_chosen;

  logic [ID_W-1:0]     stored_ids    [UNITS];
  logic [HEALTH_W-1:0] stored_health [UNITS];
  int                  stored_count;
  logic [SEL_W-1:0]    select_count_model = SEL_RESET;
  chosen_t             picks_due [$];
  chosen_t             oldest_pick;

  int error_count    = 0;
  int units_sent     = 0;
  int sets_sent      = 0;
  int picks_checked  = 0;
  int cycle_count    = 0;
  int sender_idle_pct = 0;

  top_k_health_selector_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_unit_id       (in_unit_id),
    .in_unit_health   (in_unit_health),
    .in_last_unit     (in_last_unit),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_select_count (cfg_select_count),
    .out_valid        (out_valid),
    .out_chosen_id    (out_chosen_id),
    .out_last_chosen  (out_last_chosen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d chosen ids still due", $time, picks_due.size());
      $display("** top_k_health_selector_core: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (picks_due.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual id %h last %b",
                 $time, out_chosen_id, out_last_chosen);
        error_count++;
      end else begin
        oldest_pick = picks_due.pop_front();
        picks_checked++;
        if (out_chosen_id !== oldest_pick.id) begin
          $display("%0t: chosen_id mismatch: expected %h, actual %h",
                   $time, oldest_pick.id, out_chosen_id);
          error_count++;
        end
        if (out_last_chosen !== oldest_pick.last) begin
          $display("%0t: last_chosen mismatch: expected %b, actual %b",
                   $time, oldest_pick.last, out_last_chosen);
          error_count++;
        end
      end
    end
  end

  // Store the unit; on the closing unit, choose ids and queue them in pick order.
  task automatic choose_units(input logic [ID_W-1:0] id, input logic [HEALTH_W-1:0] hp,
                              input logic last);
    int      order [$];
    logic    taken [UNITS];
    int      best;
    int      pick;
    int      picked;
    int      additions;
    bit      found;
    chosen_t entry;
    if (stored_count < UNITS) begin
      stored_ids[stored_count]    = id;
      stored_health[stored_count] = hp;
      stored_count++;
    end
    if (!last) return;
    for (int i = 0; i < UNITS; i++) taken[i] = 1'b0;
    if (stored_count <= int'(select_count_model)) begin
      for (int i = 0; i < stored_count; i++) order = {order, i};
    end else begin
      best = 0;
      for (int i = 1; i < stored_count; i++)
        if (stored_health[i] > stored_health[best]) best = i;
      taken[best] = 1'b1;
      order = {order, best};
      picked    = 1;
      additions = 0;
      while (picked < int'(select_count_model) && additions < ADDS) begin
        found = 1'b0;
        pick  = 0;
        for (int i = 0; i < stored_count; i++) begin
          if (!taken[i] && (!found || stored_health[i] >= stored_health[pick])) begin
            pick  = i;
            found = 1'b1;
          end
        end
        if (found) begin
          taken[pick] = 1'b1;
          order = {order, pick};
          picked++;
        end
        additions++;
      end
    end
    foreach (order[k]) begin
      entry.id   = stored_ids[order[k]];
      entry.last = (k == order.size() - 1);
      picks_due = {picks_due, entry};
    end
    stored_count = 0;
    sets_sent++;
  endtask

  task automatic load_unit(input logic [ID_W-1:0] id, input logic [HEALTH_W-1:0] hp,
                           input logic last);
    int gap;
    @(negedge clk);
    start          <= 1'b1;
    in_unit_id     <= id;
    in_unit_health <= hp;
    in_last_unit   <= last;
    do @(posedge clk); while (busy);
    choose_units(id, hp, last);
    units_sent++;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop start, wait for every due id, then let the chain clear.
  task automatic settle_block;
    @(negedge clk);
    start <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (PASS_CYCLES) @(posedge clk);
  endtask

  task automatic write_select_count(input logic [SEL_W-1:0] value);
    settle_block();
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_select_count <= value;
    do @(posedge clk); while (!cfg_ready);
    select_count_model = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [HEALTH_W-1:0] draw_health();
    case ($urandom_range(3))
      0:       return HEALTH_W'($urandom_range(3));
      1:       return 16'hFFFF - HEALTH_W'($urandom_range(1));
      default: return HEALTH_W'($urandom_range(16'hFFFF));
    endcase
  endfunction

  function automatic logic [ID_W-1:0] draw_id();
    if ($urandom_range(3) == 0) return ID_W'($urandom_range(3));
    return ID_W'($urandom_range(255));
  endfunction

  task automatic load_random_set(input int size);
    for (int k = 0; k < size; k++) load_unit(draw_id(), draw_health(), k == size - 1);
  endtask

  task automatic test_default_count;
    load_unit(8'h00, 16'h0000, 1'b0);
    load_unit(8'hFF, 16'hFFFF, 1'b0);
    load_unit(8'h55, 16'h5555, 1'b0);
    load_unit(8'hAA, 16'hAAAA, 1'b1);
  endtask

  task automatic test_health_ties;
    for (int k = 1; k <= 6; k++) load_unit(ID_W'(k), 16'h8000, k == 6);
  endtask

  task automatic test_zero_count;
    write_select_count(7'd0);
    load_unit(8'h10, 16'h0001, 1'b0);
    load_unit(8'h11, 16'hFFFF, 1'b0);
    load_unit(8'h12, 16'hFFFF, 1'b1);
    load_unit(8'h20, 16'h0000, 1'b1);
  endtask

  task automatic test_count_above;
    write_select_count(7'h7F);
    load_unit(8'h77, 16'h0003, 1'b0);
    load_unit(8'h77, 16'hFFFE, 1'b0);
    load_unit(8'h77, 16'h0000, 1'b0);
    load_unit(8'h80, 16'h7FFF, 1'b0);
    load_unit(8'h01, 16'h8001, 1'b1);
    write_select_count(7'd1);
    load_unit(8'h33, 16'h1234, 1'b1);
    load_unit(8'h44, 16'h0010, 1'b0);
    load_unit(8'h45, 16'h0020, 1'b1);
  endtask

  task automatic test_store_full;
    write_select_count(7'd30);
    load_random_set(UNITS + 2);
  endtask

  task automatic test_random_sets(input int idle_pct, input logic [SEL_W-1:0] count);
    int budget;
    int size;
    write_select_count(count);
    sender_idle_pct = idle_pct;
    budget = 0;
    while (budget < 8) begin
      size = $urandom_range(1, 8);
      load_random_set(size);
      budget += size;
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_default_count();
    test_health_ties();
    test_zero_count();
    test_count_above();
    test_store_full();
    test_random_sets(0, SEL_W'($urandom_range(2, 8)));
    test_random_sets(66, SEL_W'($urandom_range(0, 5)));
    test_random_sets(0, 7'd3);
    test_random_sets(23, SEL_W'($urandom_range(0, 64)));
    settle_block();

    $display("Sent %0d units in %0d sets; checked %0d chosen ids.",
             units_sent, sets_sent, picks_checked);
    $display("Covered ties, zero and oversized counts, full store and addition cap.");
    if (error_count == 0) begin
      $display("** top_k_health_selector_core: PASSED **");
    end else begin
      $display("** top_k_health_selector_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/thks_pkg.sv
rtl/core/thks_cell.sv
rtl/core/thks_scan.sv
rtl/core/top_k_health_selector_core.sv
tb/tb_top_k_health_selector_core.sv
